// File: rtl/ptd_pkg.sv
package ptd_pkg;

  // coordinate and register widths
  localparam int COORD_W   = 16;
  localparam int VTX_W     = 3 * COORD_W;
  localparam int CFG_IDX_W = 2;

  // difference vectors, dot products, wide determinants
  localparam int DIF_W  = COORD_W + 1;
  localparam int PRD_W  = 2 * DIF_W;
  localparam int DOT_W  = PRD_W + 1;
  localparam int WIDE_W = 2 * DOT_W + 2;

  // barycentric parameters
  localparam int PARAM_BITS = 24;
  localparam int GUARD_BITS = 8;
  localparam int PAR_W      = PARAM_BITS + 1;
  localparam logic [PAR_W-1:0] PAR_ONE = {1'b1, {PARAM_BITS{1'b0}}};

  // closest point and norm
  localparam int SCL_W  = PAR_W + DIF_W + 1;
  localparam int W_W    = SCL_W + 2;
  localparam int MAG_W  = W_W - (PARAM_BITS - GUARD_BITS);
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int ROOT_W = SUM_W / 2;
  localparam int DIST_W = ROOT_W + 1 - GUARD_BITS;
  localparam int OUT_W  = 17;
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  // pipeline depths
  localparam int FRONT_LAT = 6;
  localparam int DIV_LAT   = PARAM_BITS + 1;
  localparam int BACK_LAT  = 5;
  localparam int TAIL_LAT  = DIV_LAT + BACK_LAT + ROOT_W;
  localparam int TOTAL_LAT = FRONT_LAT + TAIL_LAT + 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_THIRD  = 2'd2;

  // parameter source codes
  localparam logic [1:0] SEL_ZERO = 2'd0;
  localparam logic [1:0] SEL_ONE  = 2'd1;
  localparam logic [1:0] SEL_QUO  = 2'd2;
  localparam logic [1:0] SEL_CMP  = 2'd3;

  typedef logic signed [DIF_W-1:0] ptd_dif_t;

  typedef struct packed {
    ptd_dif_t [2:0] d;
    ptd_dif_t [2:0] e0;
    ptd_dif_t [2:0] e1;
  } ptd_geom_t;

  typedef struct packed {
    logic [1:0] s;
    logic [1:0] t;
  } ptd_sel_t;

endpackage

// File: rtl/ptd_front.sv
module ptd_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_fire,
  input  logic signed [ptd_pkg::COORD_W-1:0]  px,
  input  logic signed [ptd_pkg::COORD_W-1:0]  py,
  input  logic signed [ptd_pkg::COORD_W-1:0]  pz,
  input  logic        [ptd_pkg::VTX_W-1:0]    vtx0,
  input  logic        [ptd_pkg::VTX_W-1:0]    vtx1,
  input  logic        [ptd_pkg::VTX_W-1:0]    vtx2,
  output logic                                valid,
  output ptd_pkg::ptd_geom_t                  geom,
  output ptd_pkg::ptd_sel_t                   sel,
  output logic signed [ptd_pkg::WIDE_W-1:0]   num_s,
  output logic signed [ptd_pkg::WIDE_W-1:0]   den_s,
  output logic signed [ptd_pkg::WIDE_W-1:0]   num_t,
  output logic signed [ptd_pkg::WIDE_W-1:0]   den_t
);
  import ptd_pkg::*;

  function automatic ptd_dif_t crd(input logic [VTX_W-1:0] v, input int k);
    return DIF_W'($signed(v[k*COORD_W +: COORD_W]));
  endfunction

  logic                     vld_r [FRONT_LAT];
  ptd_geom_t                geom_r [FRONT_LAT];
  ptd_geom_t                geom_nxt;
  logic signed [COORD_W-1:0] pnt [3];

  logic signed [PRD_W-1:0]  pa_r [3], pb_r [3], pc_r [3], pd_r [3], pe_r [3];
  logic signed [DOT_W-1:0]  a3_r, b3_r, c3_r, d3_r, e3_r;
  logic signed [DOT_W-1:0]  a4_r, b4_r, c4_r, d4_r, e4_r;
  logic signed [DOT_W-1:0]  a5_r, b5_r, c5_r, d5_r, e5_r;
  logic signed [WIDE_W-1:0] ac_r, bb_r, be_r, cd_r, bd_r, ae_r;
  logic signed [WIDE_W-1:0] det_r, sn_r, tn_r;

  ptd_sel_t                 sel_r, sel_nxt;
  logic signed [WIDE_W-1:0] ns_r, ms_r, nt_r, mt_r;
  logic signed [WIDE_W-1:0] ns_nxt, ms_nxt, nt_nxt, mt_nxt;

  assign pnt[0] = px;
  assign pnt[1] = py;
  assign pnt[2] = pz;

  // valid bits, one per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRONT_LAT; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= in_fire;
      for (int i = 1; i < FRONT_LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // stage 1: edge and offset vectors
  always_comb begin
    geom_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      geom_nxt.e0[k] = crd(vtx1, k) - crd(vtx0, k);
      geom_nxt.e1[k] = crd(vtx2, k) - crd(vtx0, k);
      geom_nxt.d[k]  = crd(vtx0, k) - DIF_W'(pnt[k]);
    end
  end

  always_ff @(posedge clk) begin
    geom_r[0] <= geom_nxt;
    for (int i = 1; i < FRONT_LAT; i++) geom_r[i] <= geom_r[i-1];
  end

  // stage 2: per-axis products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pa_r[k] <= PRD_W'($signed(geom_r[0].e0[k])) * PRD_W'($signed(geom_r[0].e0[k]));
      pb_r[k] <= PRD_W'($signed(geom_r[0].e0[k])) * PRD_W'($signed(geom_r[0].e1[k]));
      pc_r[k] <= PRD_W'($signed(geom_r[0].e1[k])) * PRD_W'($signed(geom_r[0].e1[k]));
      pd_r[k] <= PRD_W'($signed(geom_r[0].e0[k])) * PRD_W'($signed(geom_r[0].d[k]));
      pe_r[k] <= PRD_W'($signed(geom_r[0].e1[k])) * PRD_W'($signed(geom_r[0].d[k]));
    end
  end

  // stage 3: dot products
  always_ff @(posedge clk) begin
    a3_r <= DOT_W'(pa_r[0]) + DOT_W'(pa_r[1]) + DOT_W'(pa_r[2]);
    b3_r <= DOT_W'(pb_r[0]) + DOT_W'(pb_r[1]) + DOT_W'(pb_r[2]);
    c3_r <= DOT_W'(pc_r[0]) + DOT_W'(pc_r[1]) + DOT_W'(pc_r[2]);
    d3_r <= DOT_W'(pd_r[0]) + DOT_W'(pd_r[1]) + DOT_W'(pd_r[2]);
    e3_r <= DOT_W'(pe_r[0]) + DOT_W'(pe_r[1]) + DOT_W'(pe_r[2]);
  end

  // stage 4: cross products of the dot products
  always_ff @(posedge clk) begin
    ac_r <= WIDE_W'(a3_r) * WIDE_W'(c3_r);
    bb_r <= WIDE_W'(b3_r) * WIDE_W'(b3_r);
    be_r <= WIDE_W'(b3_r) * WIDE_W'(e3_r);
    cd_r <= WIDE_W'(c3_r) * WIDE_W'(d3_r);
    bd_r <= WIDE_W'(b3_r) * WIDE_W'(d3_r);
    ae_r <= WIDE_W'(a3_r) * WIDE_W'(e3_r);
    a4_r <= a3_r;
    b4_r <= b3_r;
    c4_r <= c3_r;
    d4_r <= d3_r;
    e4_r <= e3_r;
  end

  // stage 5: determinant and unnormalized parameters
  always_ff @(posedge clk) begin
    det_r <= ac_r - bb_r;
    sn_r  <= be_r - cd_r;
    tn_r  <= bd_r - ae_r;
    a5_r  <= a4_r;
    b5_r  <= b4_r;
    c5_r  <= c4_r;
    d5_r  <= d4_r;
    e5_r  <= e4_r;
  end

  // stage 6: region select, divider operands
  always_comb begin
    logic signed [WIDE_W-1:0] aw, bw, cw, dw, ew, den, t0, t1;
    aw  = WIDE_W'(a5_r);
    bw  = WIDE_W'(b5_r);
    cw  = WIDE_W'(c5_r);
    dw  = WIDE_W'(d5_r);
    ew  = WIDE_W'(e5_r);
    den = aw - (bw <<< 1) + cw;
    t0  = '0;
    t1  = '0;
    sel_nxt = '{s: SEL_ZERO, t: SEL_ZERO};
    ns_nxt = '0;
    ms_nxt = '0;
    nt_nxt = '0;
    mt_nxt = '0;
    if ((sn_r + tn_r) <= det_r) begin
      if (sn_r[WIDE_W-1] && tn_r[WIDE_W-1]) begin
        if (dw[WIDE_W-1]) begin
          sel_nxt.s = SEL_QUO;
          ns_nxt    = -dw;
          ms_nxt    = aw;
        end else begin
          sel_nxt.t = SEL_QUO;
          nt_nxt    = -ew;
          mt_nxt    = cw;
        end
      end else if (sn_r[WIDE_W-1]) begin
        sel_nxt.t = SEL_QUO;
        nt_nxt    = -ew;
        mt_nxt    = cw;
      end else if (tn_r[WIDE_W-1]) begin
        sel_nxt.s = SEL_QUO;
        ns_nxt    = -dw;
        ms_nxt    = aw;
      end else begin
        sel_nxt = '{s: SEL_QUO, t: SEL_QUO};
        ns_nxt  = sn_r;
        ms_nxt  = det_r;
        nt_nxt  = tn_r;
        mt_nxt  = det_r;
      end
    end else if (sn_r[WIDE_W-1]) begin
      t0 = bw + dw;
      t1 = cw + ew;
      if (t1 > t0) begin
        sel_nxt = '{s: SEL_QUO, t: SEL_CMP};
        ns_nxt  = t1 - t0;
        ms_nxt  = den;
      end else if (t1 <= 0) begin
        sel_nxt.t = SEL_ONE;
      end else begin
        sel_nxt.t = SEL_QUO;
        nt_nxt    = -ew;
        mt_nxt    = cw;
      end
    end else if (tn_r[WIDE_W-1]) begin
      t0 = bw + ew;
      t1 = aw + dw;
      if (t1 > t0) begin
        sel_nxt = '{s: SEL_CMP, t: SEL_QUO};
        nt_nxt  = t1 - t0;
        mt_nxt  = den;
      end else if (t1 <= 0) begin
        sel_nxt.s = SEL_ONE;
      end else begin
        sel_nxt.s = SEL_QUO;
        ns_nxt    = -dw;
        ms_nxt    = aw;
      end
    end else begin
      t0 = cw + ew - bw - dw;
      if (t0 <= 0) begin
        sel_nxt.t = SEL_ONE;
      end else begin
        sel_nxt = '{s: SEL_QUO, t: SEL_CMP};
        ns_nxt  = t0;
        ms_nxt  = den;
      end
    end
  end

  always_ff @(posedge clk) begin
    sel_r <= sel_nxt;
    ns_r  <= ns_nxt;
    ms_r  <= ms_nxt;
    nt_r  <= nt_nxt;
    mt_r  <= mt_nxt;
  end

  assign valid = vld_r[FRONT_LAT-1];
  assign geom  = geom_r[FRONT_LAT-1];
  assign sel   = sel_r;
  assign num_s = ns_r;
  assign den_s = ms_r;
  assign num_t = nt_r;
  assign den_t = mt_r;

endmodule

// File: rtl/ptd_div.sv
module ptd_div (
  input  logic                               clk,
  input  logic signed [ptd_pkg::WIDE_W-1:0]  num,
  input  logic signed [ptd_pkg::WIDE_W-1:0]  den,
  output logic        [ptd_pkg::PAR_W-1:0]   quo
);
  import ptd_pkg::*;

  localparam int REM_W = WIDE_W + 1;

  logic [REM_W-1:0]      rem_r [PARAM_BITS];
  logic [REM_W-1:0]      dvs_r [PARAM_BITS];
  logic [PARAM_BITS-1:0] q_r [DIV_LAT];
  logic                  zero_r [DIV_LAT];
  logic                  one_r [DIV_LAT];

  // entry stage: quotient clamps to 0 or 1.0 outside the open range
  always_ff @(posedge clk) begin
    zero_r[0] <= (num <= 0);
    one_r[0]  <= (num > 0) && (den <= num);
    rem_r[0]  <= REM_W'($unsigned(num));
    dvs_r[0]  <= REM_W'($unsigned(den));
    q_r[0]    <= '0;
  end

  // one quotient bit per stage, restoring
  for (genvar j = 1; j < DIV_LAT; j++) begin : g_step
    logic [REM_W-1:0] sh;
    logic             ge;

    assign sh = {rem_r[j-1][REM_W-2:0], 1'b0};
    assign ge = (sh >= dvs_r[j-1]);

    always_ff @(posedge clk) begin
      q_r[j]    <= {q_r[j-1][PARAM_BITS-2:0], ge};
      zero_r[j] <= zero_r[j-1];
      one_r[j]  <= one_r[j-1];
    end

    if (j < PARAM_BITS) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[j] <= ge ? (sh - dvs_r[j-1]) : sh;
        dvs_r[j] <= dvs_r[j-1];
      end
    end
  end

  assign quo = zero_r[DIV_LAT-1] ? '0 :
               one_r[DIV_LAT-1]  ? PAR_ONE : {1'b0, q_r[DIV_LAT-1]};

endmodule

// File: rtl/ptd_sqrt.sv
module ptd_sqrt (
  input  logic                            clk,
  input  logic [ptd_pkg::SUM_W-1:0]       rad,
  output logic [ptd_pkg::ROOT_W-1:0]      root
);
  import ptd_pkg::*;

  logic [SUM_W-1:0] n_r [ROOT_W-1];
  logic [SUM_W-1:0] res_r [ROOT_W];

  // one root bit per stage, from the top down
  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (ROOT_W - 1 - k));
    logic [SUM_W-1:0] n_in, res_in, trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign n_in   = rad;
      assign res_in = '0;
    end else begin : g_next
      assign n_in   = n_r[k-1];
      assign res_in = res_r[k-1];
    end

    assign trial = res_in + BIT;
    assign ge    = (n_in >= trial);

    always_ff @(posedge clk) begin
      res_r[k] <= ge ? ((res_in >> 1) + BIT) : (res_in >> 1);
    end

    if (k < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        n_r[k] <= ge ? (n_in - trial) : n_in;
      end
    end
  end

  assign root = res_r[ROOT_W-1][ROOT_W-1:0];

endmodule

// File: rtl/point_triangle_distance.sv
// Point-to-triangle distance, fully pipelined. One query point is taken in
// every clock cycle; busy never rises. Each result appears on
// out_distance_out for a single cycle with out_valid high, in query
// order; the receiver must take it then. The pipeline is built from the
// 25-stage parameter dividers (an entry clamp stage, then one quotient bit
// per stage) and the 30-stage square root (one root bit per stage), plus
// twelve stages of products, region select and rounding. The user must
// write vertices through the cfg port only while no query is in flight;
// the block itself does not enforce this.
module point_triangle_distance (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ptd_pkg::COORD_W-1:0]  in_point_x,
  input  logic signed [ptd_pkg::COORD_W-1:0]  in_point_y,
  input  logic signed [ptd_pkg::COORD_W-1:0]  in_point_z,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [ptd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [ptd_pkg::VTX_W-1:0]    cfg_data,
  output logic                                out_valid,
  output logic        [ptd_pkg::OUT_W-1:0]    out_distance_out
);
  import ptd_pkg::*;

  logic [VTX_W-1:0]  vtx0_r, vtx1_r, vtx2_r;
  logic              fr_valid;
  ptd_geom_t         fr_geom;
  ptd_sel_t          fr_sel;
  logic signed [WIDE_W-1:0] num_s, den_s, num_t, den_t;
  logic [PAR_W-1:0]  quo_s, quo_t;

  logic              vld_r [TAIL_LAT];
  ptd_geom_t         geom_d_r [DIV_LAT];
  ptd_sel_t          sel_d_r [DIV_LAT];

  logic [PAR_W-1:0]  ps_r, pt_r, ps_nxt, pt_nxt;
  ptd_geom_t         geom_b1_r;
  ptd_dif_t [2:0]    d_b2_r;
  logic signed [SCL_W-1:0] scs_r [3], sct_r [3];
  logic [MAG_W-1:0]  mag_r [3];
  logic [SQ_W-1:0]   sq_r [3];
  logic [SUM_W-1:0]  sum_r;
  logic [ROOT_W-1:0] root;
  logic [DIST_W-1:0] dist_w;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_dist_r;

  // never refuses a query or a config transaction
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // vertex registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vtx0_r <= '0;
      vtx1_r <= '0;
      vtx2_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VERTEX_FIRST:  vtx0_r <= cfg_data;
        REG_VERTEX_SECOND: vtx1_r <= cfg_data;
        REG_VERTEX_THIRD:  vtx2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ptd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (start && !busy),
    .px      (in_point_x),
    .py      (in_point_y),
    .pz      (in_point_z),
    .vtx0    (vtx0_r),
    .vtx1    (vtx1_r),
    .vtx2    (vtx2_r),
    .valid   (fr_valid),
    .geom    (fr_geom),
    .sel     (fr_sel),
    .num_s   (num_s),
    .den_s   (den_s),
    .num_t   (num_t),
    .den_t   (den_t)
  );

  ptd_div u_div_s (.clk(clk), .num(num_s), .den(den_s), .quo(quo_s));
  ptd_div u_div_t (.clk(clk), .num(num_t), .den(den_t), .quo(quo_t));

  // valid bits behind the front end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAIL_LAT; i++) vld_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r[0] <= fr_valid;
      for (int i = 1; i < TAIL_LAT; i++) vld_r[i] <= vld_r[i-1];
      out_valid_r <= vld_r[TAIL_LAT-1];
    end
  end

  // side data alongside the dividers
  always_ff @(posedge clk) begin
    geom_d_r[0] <= fr_geom;
    sel_d_r[0]  <= fr_sel;
    for (int i = 1; i < DIV_LAT; i++) begin
      geom_d_r[i] <= geom_d_r[i-1];
      sel_d_r[i]  <= sel_d_r[i-1];
    end
  end

  // back 1: pick the clamped parameters
  always_comb begin
    case (sel_d_r[DIV_LAT-1].s)
      SEL_ZERO: ps_nxt = '0;
      SEL_ONE:  ps_nxt = PAR_ONE;
      SEL_QUO:  ps_nxt = quo_s;
      SEL_CMP:  ps_nxt = PAR_ONE - quo_t;
      default:  ps_nxt = '0;
    endcase
    case (sel_d_r[DIV_LAT-1].t)
      SEL_ZERO: pt_nxt = '0;
      SEL_ONE:  pt_nxt = PAR_ONE;
      SEL_QUO:  pt_nxt = quo_t;
      SEL_CMP:  pt_nxt = PAR_ONE - quo_s;
      default:  pt_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    ps_r      <= ps_nxt;
    pt_r      <= pt_nxt;
    geom_b1_r <= geom_d_r[DIV_LAT-1];
  end

  // back 2: scale the edges
  always_ff @(posedge clk) begin
    d_b2_r <= geom_b1_r.d;
    for (int k = 0; k < 3; k++) begin
      scs_r[k] <= SCL_W'($signed({1'b0, ps_r})) * SCL_W'($signed(geom_b1_r.e0[k]));
      sct_r[k] <= SCL_W'($signed({1'b0, pt_r})) * SCL_W'($signed(geom_b1_r.e1[k]));
    end
  end

  function automatic logic [MAG_W-1:0] mag_of(input ptd_dif_t dv,
                                              input logic signed [SCL_W-1:0] s0,
                                              input logic signed [SCL_W-1:0] s1);
    logic signed [W_W-1:0] w;
    logic [W_W-1:0]        m;
    w = (W_W'($signed(dv)) <<< PARAM_BITS) + W_W'(s0) + W_W'(s1);
    m = w[W_W-1] ? W_W'(-w) : W_W'(w);
    m = m + (W_W'(1) << (PARAM_BITS - GUARD_BITS - 1));
    return m[W_W-1 -: MAG_W];
  endfunction

  // back 3: offset to the closest point, magnitude rounded half up
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      mag_r[k] <= mag_of(d_b2_r[k], scs_r[k], sct_r[k]);
    end
  end

  // back 4: squares
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) sq_r[k] <= SQ_W'(mag_r[k]) * SQ_W'(mag_r[k]);
  end

  // back 5: squared distance
  always_ff @(posedge clk) begin
    sum_r <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
  end

  ptd_sqrt u_sqrt (.clk(clk), .rad(sum_r), .root(root));

  // final rounding and saturation at OUT_MAX
  assign dist_w = DIST_W'(((ROOT_W+1)'(root) + (ROOT_W+1)'(1 << (GUARD_BITS - 1)))
                          >> GUARD_BITS);

  always_ff @(posedge clk) begin
    out_dist_r <= (dist_w > DIST_W'(OUT_MAX)) ? OUT_MAX : dist_w[OUT_W-1:0];
  end

  assign out_valid        = out_valid_r;
  assign out_distance_out = out_dist_r;

endmodule

// File: rtl/ptd_checker.sv
module ptd_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic cfg_valid,
  input logic cfg_ready,
  input logic out_valid
);
  import ptd_pkg::*;

  // every accepted query yields its result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##TOTAL_LAT out_valid)
    else $error("ptd: accepted query produced no result at the expected cycle");

  // no result without a query accepted the latency earlier
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, TOTAL_LAT))
    else $error("ptd: result without a matching query");

  // the pipeline never pushes back on queries
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("ptd: busy asserted");

  // config transactions always complete at once
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("ptd: config transaction stalled");

endmodule

bind point_triangle_distance ptd_checker u_ptd_checker (.*);

// File: test/tb_top.sv
module tb_top;
  import ptd_pkg::*;

  typedef logic signed [127:0] wide_t;
  localparam longint ONE = longint'(1) << PARAM_BITS;
  localparam int IDLE_LIMIT = 4000;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  // Golden distance calculator plus queue of pending distances
  class dist_scoreboard;
    logic [VTX_W-1:0] vtx [3];
    logic [OUT_W-1:0] pending_dist [$];
    int mismatches;

    function new();
      for (int k = 0; k < 3; k++) vtx[k] = '0;
      mismatches = 0;
    endfunction

    function void write_vertex(logic [CFG_IDX_W-1:0] idx, logic [VTX_W-1:0] val);
      if (idx == REG_VERTEX_FIRST) vtx[0] = val;
      else if (idx == REG_VERTEX_SECOND) vtx[1] = val;
      else if (idx == REG_VERTEX_THIRD) vtx[2] = val;
    endfunction

    function longint coord(logic [VTX_W-1:0] v, int k);
      logic signed [COORD_W-1:0] f;
      f = v[k*COORD_W +: COORD_W];
      return longint'(f);
    endfunction

    // n/m in [0,1] with PARAM_BITS fraction bits, truncated
    function longint ratio(wide_t n, wide_t m);
      longint q;
      wide_t r;
      q = 0;
      r = n;
      if (n <= 0) return 0;
      if (m <= n) return ONE;
      for (int i = 0; i < PARAM_BITS; i++) begin
        r = r <<< 1;
        q = q << 1;
        if (m <= r) begin
          r = r - m;
          q = q | 1;
        end
      end
      return q;
    endfunction

    function longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function logic [OUT_W-1:0] distance(longint px, longint py, longint pz);
      longint bv [3], e0 [3], e1 [3], dv [3], pin [3];
      longint a, b, c, d, e, t0, t1, ps, pt, w;
      longint unsigned mag, sum, root, dist_v;
      wide_t det, sn, tn;
      pin[0] = px; pin[1] = py; pin[2] = pz;
      a = 0; b = 0; c = 0; d = 0; e = 0; sum = 0;
      for (int k = 0; k < 3; k++) begin
        bv[k] = coord(vtx[0], k);
        e0[k] = coord(vtx[1], k) - bv[k];
        e1[k] = coord(vtx[2], k) - bv[k];
        dv[k] = bv[k] - pin[k];
        a += e0[k] * e0[k]; b += e0[k] * e1[k]; c += e1[k] * e1[k];
        d += e0[k] * dv[k]; e += e1[k] * dv[k];
      end
      det = wide_t'(a) * wide_t'(c) - wide_t'(b) * wide_t'(b);
      sn = wide_t'(b) * wide_t'(e) - wide_t'(c) * wide_t'(d);
      tn = wide_t'(b) * wide_t'(d) - wide_t'(a) * wide_t'(e);

      // seven-region clamp
      if (sn + tn <= det) begin
        if (sn < 0 && tn < 0) begin
          if (d < 0) begin
            pt = 0; ps = ratio(-d, a);
          end else begin
            ps = 0; pt = (e >= 0) ? 0 : ratio(-e, c);
          end
        end else if (sn < 0) begin
          ps = 0; pt = (e >= 0) ? 0 : ratio(-e, c);
        end else if (tn < 0) begin
          pt = 0; ps = (d >= 0) ? 0 : ratio(-d, a);
        end else begin
          ps = ratio(sn, det); pt = ratio(tn, det);
        end
      end else if (sn < 0) begin
        t0 = b + d; t1 = c + e;
        if (t1 > t0) begin
          ps = ratio(t1 - t0, a - 2 * b + c); pt = ONE - ps;
        end else begin
          ps = 0;
          if (t1 <= 0) pt = ONE;
          else pt = (e >= 0) ? 0 : ratio(-e, c);
        end
      end else if (tn < 0) begin
        t0 = b + e; t1 = a + d;
        if (t1 > t0) begin
          pt = ratio(t1 - t0, a - 2 * b + c); ps = ONE - pt;
        end else begin
          pt = 0;
          if (t1 <= 0) ps = ONE;
          else ps = (d >= 0) ? 0 : ratio(-d, a);
        end
      end else begin
        t0 = c + e - b - d;
        if (t0 <= 0) begin
          ps = 0; pt = ONE;
        end else begin
          ps = ratio(t0, a - 2 * b + c); pt = ONE - ps;
        end
      end

      // norm of Q - P with guard-bit rounding
      for (int k = 0; k < 3; k++) begin
        w = dv[k] * ONE + ps * e0[k] + pt * e1[k];
        mag = (w < 0) ? longint'(-w) : longint'(w);
        mag = (mag + (64'd1 << (PARAM_BITS - GUARD_BITS - 1))) >> (PARAM_BITS - GUARD_BITS);
        sum += mag * mag;
      end
      root = floor_sqrt(sum);
      dist_v = (root + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS;
      if (dist_v > 64'd131071) dist_v = 64'd131071;
      return dist_v[OUT_W-1:0];
    endfunction

    function void note_query(longint px, longint py, longint pz);
      pending_dist.push_back(distance(px, py, pz));
    endfunction

    function void check_distance(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (pending_dist.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected distance %0d", got);
        return;
      end
      want = pending_dist.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("distance mismatch: expected %0d got %0d", want, got);
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy, cfg_valid, cfg_ready, out_valid;
  logic signed [COORD_W-1:0] in_point_x, in_point_y, in_point_z;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VTX_W-1:0] cfg_data;
  logic [OUT_W-1:0] out_distance_out;
  dist_scoreboard sb;
  int idle_cycles;
  bit bursty;

  point_triangle_distance dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // monitor: accepted transactions feed the scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_query(in_point_x, in_point_y, in_point_z);
      if (out_valid) sb.check_distance(out_distance_out);
      if (cfg_valid && cfg_ready) sb.write_vertex(cfg_index, cfg_data);
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("point_triangle_distance verification failed");
      $finish;
    end
  end

  task automatic send_point(int x, int y, int z);
    int gap;
    gap = bursty ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_point_x <= COORD_W'(x); in_point_y <= COORD_W'(y); in_point_z <= COORD_W'(z);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // quiet the point channel, then drain in-flight queries
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_dist.size() != 0) @(posedge clk);
    repeat (TOTAL_LAT + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VTX_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [VTX_W-1:0] pack(int x, int y, int z);
    logic [COORD_W-1:0] fx, fy, fz;
    fx = COORD_W'(x); fy = COORD_W'(y); fz = COORD_W'(z);
    return {fz, fy, fx};
  endfunction

  task automatic set_triangle(logic [VTX_W-1:0] v0, v1, v2);
    drain();
    write_reg(REG_VERTEX_FIRST, v0);
    write_reg(REG_VERTEX_SECOND, v1);
    write_reg(REG_VERTEX_THIRD, v2);
  endtask

  function automatic int rnd_coord();
    return int'($signed(16'($urandom)));
  endfunction

  initial begin
    logic [VTX_W-1:0] tri_v [3];
    int spread, sel, cx, cy, cz;
    sb = new();
    rst_n = 0; start = 0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    in_point_x = '0; in_point_y = '0; in_point_z = '0;
    idle_cycles = 0; bursty = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // degenerate triangle at origin straight after reset
    send_point(16'sh7fff, 16'sh8000, 16'sh0000);
    send_point(16'sh8000, 16'sh8000, 16'sh8000);

    // unit right triangle in z=0, points in every region
    set_triangle(pack(0, 0, 0), pack(256, 0, 0), pack(0, 256, 0));
    write_reg(REG_UNMAPPED, '1); // unmapped index, must be ignored
    send_point(64, 64, 100);     // over the face
    send_point(-100, -100, 0);   // beyond vertex 0
    send_point(400, -50, 10);    // beyond vertex 1
    send_point(-50, 400, -10);   // beyond vertex 2
    send_point(200, 200, 0);     // beyond hypotenuse
    send_point(100, -80, 0);     // below edge 0
    send_point(-80, 100, 0);     // left of edge 1
    send_point(500, 20, 0);      // past vertex 1 along x
    send_point(20, 500, 0);      // past vertex 2 along y
    send_point(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_point(16'sh8000, 16'sh8000, 16'sh8000);

    // collinear triangle: zero determinant
    set_triangle(pack(0, 0, 0), pack(512, 0, 0), pack(1024, 0, 0));
    send_point(300, 300, 300);
    send_point(-300, 0, 0);
    send_point(2000, -5, 7);

    // extreme vertices
    set_triangle(pack(-32768, -32768, -32768), pack(32767, -32768, 32767),
                 pack(-32768, 32767, 32767));
    send_point(16'sh7fff, 16'sh7fff, 16'sh8000);
    send_point(16'sh8000, 16'sh7fff, 16'sh7fff);
    send_point(16'sh0000, 16'sh0000, 16'sh0000);
    send_point(16'sh8000, 16'sh8000, 16'sh8000);
    send_point(16'sh7fff, 16'sh8000, 16'sh7fff);

    // random triangles, mostly small, points clustered near them
    for (int ph = 0; ph < 10; ph++) begin
      spread = (ph % 3 == 0) ? 32767 : $urandom_range(16, 4096);
      cx = $urandom_range(0, 40000) - 20000;
      cy = $urandom_range(0, 40000) - 20000;
      cz = $urandom_range(0, 40000) - 20000;
      for (int k = 0; k < 3; k++)
        tri_v[k] = (spread == 32767) ? pack(rnd_coord(), rnd_coord(), rnd_coord()) :
          pack(cx + $urandom_range(0, 2 * spread) - spread,
               cy + $urandom_range(0, 2 * spread) - spread,
               cz + $urandom_range(0, 2 * spread) - spread);
      if (ph == 4) tri_v[2] = tri_v[1]; // two coincident vertices
      set_triangle(tri_v[0], tri_v[1], tri_v[2]);
      bursty = (ph % 4 == 1);
      for (int i = 0; i < 125; i++) begin
        sel = $urandom_range(0, 3);
        if (sel == 0) begin
          send_point(rnd_coord(), rnd_coord(), rnd_coord());
        end else begin
          cx = int'(sb.coord(tri_v[sel-1], 0)); cy = int'(sb.coord(tri_v[sel-1], 1));
          cz = int'(sb.coord(tri_v[sel-1], 2));
          send_point(16'(cx + $urandom_range(0, 2 * spread) - spread),
                     16'(cy + $urandom_range(0, 2 * spread) - spread),
                     16'(cz + $urandom_range(0, 2 * spread) - spread));
        end
      end
      bursty = 0;
    end

    drain();
    if (sb.mismatches == 0 && sb.pending_dist.size() == 0) begin
      $display("point_triangle_distance verification clean");
    end else begin
      $display("point_triangle_distance verification failed");
    end
    $finish;
  end

endmodule
